// ===== design/nntp_pkg.sv =====
// shared types, codes and helpers of the nntp client session controller
// no dependencies; imported by every module of the block

package nntp_pkg;

  // queue geometry, both the event queue and the result queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // opcodes of an input item
  localparam logic [3:0] OP_CONNECT = 4'd0;
  localparam logic [3:0] OP_STATUS  = 4'd1;
  localparam logic [3:0] OP_BODY    = 4'd2;
  localparam logic [3:0] OP_TLS     = 4'd3;
  localparam logic [3:0] OP_RTO     = 4'd4;
  localparam logic [3:0] OP_ITO     = 4'd5;
  localparam logic [3:0] OP_SUBMIT  = 4'd6;
  localparam logic [3:0] OP_CLOSE   = 4'd7;
  localparam logic [3:0] OP_LOST    = 4'd8;
  localparam logic [3:0] OP_ERROR   = 4'd9;
  localparam logic [3:0] OP_ABORT   = 4'd10;

  // socket error kinds
  localparam logic [1:0] SOCK_TLS_FAIL = 2'd0;
  localparam logic [1:0] SOCK_REMOTE   = 2'd1;

  // actions of a result item
  localparam logic [3:0] ACT_NONE      = 4'd0;
  localparam logic [3:0] ACT_OPEN      = 4'd1;
  localparam logic [3:0] ACT_OPEN_TLS  = 4'd2;
  localparam logic [3:0] ACT_STARTTLS  = 4'd3;
  localparam logic [3:0] ACT_MODE      = 4'd4;
  localparam logic [3:0] ACT_USER      = 4'd5;
  localparam logic [3:0] ACT_PASS      = 4'd6;
  localparam logic [3:0] ACT_REQUEST   = 4'd7;
  localparam logic [3:0] ACT_QUIT      = 4'd8;
  localparam logic [3:0] ACT_START_TLS = 4'd9;
  localparam logic [3:0] ACT_HANGUP    = 4'd10;
  localparam logic [3:0] ACT_ABORT     = 4'd11;

  // error kinds
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_CONNECT  = 3'd1;
  localparam logic [2:0] ERR_TLS      = 3'd2;
  localparam logic [2:0] ERR_PROTOCOL = 3'd3;
  localparam logic [2:0] ERR_UNAVAIL  = 3'd4;
  localparam logic [2:0] ERR_AUTH     = 3'd5;
  localparam logic [2:0] ERR_TIMEOUT  = 3'd6;
  localparam logic [2:0] ERR_DISC     = 3'd7;

  // tls modes
  localparam logic [1:0] TLS_IMPLICIT = 2'd1;
  localparam logic [1:0] TLS_STARTTLS = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_TLS_MODE = 2'd0;
  localparam logic [1:0] CFG_HAS_USER = 2'd1;
  localparam logic [1:0] CFG_IDLE_EN  = 2'd2;
  localparam logic [1:0] CFG_RESP_EN  = 2'd3;

  // server reply codes
  localparam logic [9:0] CODE_200 = 10'd200;
  localparam logic [9:0] CODE_201 = 10'd201;
  localparam logic [9:0] CODE_281 = 10'd281;
  localparam logic [9:0] CODE_381 = 10'd381;
  localparam logic [9:0] CODE_382 = 10'd382;
  localparam logic [9:0] CODE_400 = 10'd400;
  localparam logic [9:0] CODE_481 = 10'd481;
  localparam logic [9:0] CODE_482 = 10'd482;
  localparam logic [9:0] CODE_500 = 10'd500;
  localparam logic [9:0] CODE_502 = 10'd502;

  typedef enum logic [11:0] {
    EV_CONNECT = 12'b0000_0000_0001,
    EV_STATUS  = 12'b0000_0000_0010,
    EV_BODY    = 12'b0000_0000_0100,
    EV_TLS     = 12'b0000_0000_1000,
    EV_RTO     = 12'b0000_0001_0000,
    EV_ITO     = 12'b0000_0010_0000,
    EV_SUBMIT  = 12'b0000_0100_0000,
    EV_CLOSE   = 12'b0000_1000_0000,
    EV_LOST    = 12'b0001_0000_0000,
    EV_ERROR   = 12'b0010_0000_0000,
    EV_ABORT   = 12'b0100_0000_0000,
    EV_NONE    = 12'b1000_0000_0000
  } ev_kind_t;

  typedef enum logic [9:0] {
    PH_DISC  = 10'b00_0000_0001,
    PH_GREET = 10'b00_0000_0010,
    PH_STLS  = 10'b00_0000_0100,
    PH_MODE  = 10'b00_0000_1000,
    PH_USER  = 10'b00_0001_0000,
    PH_PASS  = 10'b00_0010_0000,
    PH_READY = 10'b00_0100_0000,
    PH_CSTAT = 10'b00_1000_0000,
    PH_CBODY = 10'b01_0000_0000,
    PH_QUIT  = 10'b10_0000_0000
  } phase_t;

  // classified event as it travels from front to back
  typedef struct packed {
    ev_kind_t   kind;
    logic       code_valid;
    logic       c_greet_ok;   // 200 or 201
    logic       c_unavail;    // 400 or 502
    logic       c_382;
    logic       c_381;
    logic       c_281;
    logic       c_auth_fail;  // 481, 482 or 502
    logic       c_ge500;
    logic       term;
    logic       ldot;
    logic       cfail;
    logic       cbody;
    logic [2:0] sock_err;     // error kind already mapped
    logic       srv;
  } ev_t;

  typedef struct packed {
    logic [3:0] action;
    logic       arm_response;
    logic       start_idle;
    logic       stop_timers;
    logic [2:0] error_kind;
    logic       command_done;
    logic       forward_status;
    logic       forward_body;
    logic       strip_first_byte;
    logic       became_ready;
    logic       closed_notice;
    logic [3:0] session_phase;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] index;
    logic [1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [1:0] tls_mode;
    logic       has_user;
    logic       idle_en;
    logic       resp_en;
  } cfg_t;

  function automatic logic [3:0] phase_code(phase_t p);
    logic [3:0] c;
    unique case (p)
      PH_DISC:  c = 4'd0;
      PH_GREET: c = 4'd1;
      PH_STLS:  c = 4'd2;
      PH_MODE:  c = 4'd3;
      PH_USER:  c = 4'd4;
      PH_PASS:  c = 4'd5;
      PH_READY: c = 4'd6;
      PH_CSTAT: c = 4'd7;
      PH_CBODY: c = 4'd8;
      PH_QUIT:  c = 4'd9;
      default:  c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== design/nntp_front.sv =====
// front end: decodes the opcode and pre-classifies the reply code of an item
// depends on nntp_pkg

module nntp_front
  import nntp_pkg::*;
(
  input  logic [3:0] opcode,
  input  logic [9:0] status_code,
  input  logic       code_valid,
  input  logic       body_is_terminator,
  input  logic       body_leading_dot,
  input  logic       cmd_reports_failed,
  input  logic       cmd_expects_body,
  input  logic [1:0] sock_error_kind,
  input  logic       server_valid,
  output ev_t        ev
);

  always_comb begin
    ev = '0;
    unique case (opcode)
      OP_CONNECT: ev.kind = EV_CONNECT;
      OP_STATUS:  ev.kind = EV_STATUS;
      OP_BODY:    ev.kind = EV_BODY;
      OP_TLS:     ev.kind = EV_TLS;
      OP_RTO:     ev.kind = EV_RTO;
      OP_ITO:     ev.kind = EV_ITO;
      OP_SUBMIT:  ev.kind = EV_SUBMIT;
      OP_CLOSE:   ev.kind = EV_CLOSE;
      OP_LOST:    ev.kind = EV_LOST;
      OP_ERROR:   ev.kind = EV_ERROR;
      OP_ABORT:   ev.kind = EV_ABORT;
      default:    ev.kind = EV_NONE;
    endcase
    ev.code_valid  = code_valid;
    ev.c_greet_ok  = (status_code == CODE_200) || (status_code == CODE_201);
    ev.c_unavail   = (status_code == CODE_400) || (status_code == CODE_502);
    ev.c_382       = (status_code == CODE_382);
    ev.c_381       = (status_code == CODE_381);
    ev.c_281       = (status_code == CODE_281);
    ev.c_auth_fail = (status_code == CODE_481) || (status_code == CODE_482)
                     || (status_code == CODE_502);
    ev.c_ge500     = (status_code >= CODE_500);
    ev.term        = body_is_terminator;
    ev.ldot        = body_leading_dot;
    ev.cfail       = cmd_reports_failed;
    ev.cbody       = cmd_expects_body;
    // socket error kind to session error
    priority if (sock_error_kind == SOCK_TLS_FAIL) begin
      ev.sock_err = ERR_TLS;
    end else if (sock_error_kind == SOCK_REMOTE) begin
      ev.sock_err = ERR_DISC;
    end else begin
      ev.sock_err = ERR_CONNECT;
    end
    ev.srv = server_valid;
  end

endmodule

// ===== design/nntp_evq.sv =====
// short queue of classified events between front and back
// depends on nntp_pkg

module nntp_evq
  import nntp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  ev_t  wr_data,
  output logic full,
  input  logic rd_en,
  output logic empty,
  output ev_t  rd_data
);

  ev_t               slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== design/nntp_exec.sv =====
// back end: session state, transition per event, result queue, config regs
// depends on nntp_pkg

module nntp_exec
  import nntp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg_wr,
  input  logic    ev_avail,
  input  ev_t     ev,
  output logic    ev_take,
  input  logic    pop,
  output logic    empty,
  output res_t    res
);

  cfg_t   cfg;
  phase_t phase;
  phase_t phase_next;
  logic   failed_latch;
  logic   failed_latch_next;
  logic   command_pending;
  logic   command_pending_next;

  res_t              r;
  logic              fail_req;
  logic [2:0]        fail_err;

  res_t              rq [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              room;
  logic              do_pop;

  assign empty   = (count == '0);
  assign res     = rq[rd_ptr];
  assign do_pop  = pop && !empty;
  assign room    = (count != QCNT_W'(QDEPTH)) || do_pop;
  assign ev_take = ev_avail && room;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CFG_TLS_MODE: cfg.tls_mode <= cfg_wr.data;
        CFG_HAS_USER: cfg.has_user <= cfg_wr.data[0];
        CFG_IDLE_EN:  cfg.idle_en  <= cfg_wr.data[0];
        CFG_RESP_EN:  cfg.resp_en  <= cfg_wr.data[0];
        default: ;
      endcase
    end
  end

  // transition
  always_comb begin
    r                    = '0;
    phase_next           = phase;
    failed_latch_next    = failed_latch;
    command_pending_next = command_pending;
    fail_req             = 1'b0;
    fail_err             = ERR_NONE;

    unique case (ev.kind)
      EV_CONNECT: begin
        if (phase == PH_DISC) begin
          if (!ev.srv) begin
            fail_req = 1'b1;
            fail_err = ERR_CONNECT;
          end else begin
            failed_latch_next = 1'b0;
            r.action          = (cfg.tls_mode == TLS_IMPLICIT) ? ACT_OPEN_TLS : ACT_OPEN;
            phase_next        = PH_GREET;
            r.arm_response    = cfg.resp_en;
          end
        end
      end
      EV_STATUS: begin
        if (phase != PH_CBODY) begin
          if (!ev.code_valid) begin
            fail_req = 1'b1;
            fail_err = ERR_PROTOCOL;
          end else begin
            r.stop_timers = 1'b1;
            unique case (phase)
              PH_GREET: begin
                if (ev.c_greet_ok) begin
                  if (cfg.tls_mode == TLS_STARTTLS) begin
                    phase_next = PH_STLS;
                    r.action   = ACT_STARTTLS;
                  end else begin
                    phase_next = PH_MODE;
                    r.action   = ACT_MODE;
                  end
                  r.arm_response = cfg.resp_en;
                end else begin
                  fail_req = 1'b1;
                  fail_err = ev.c_unavail ? ERR_UNAVAIL : ERR_PROTOCOL;
                end
              end
              PH_STLS: begin
                if (ev.c_382) begin
                  r.action       = ACT_START_TLS;
                  r.arm_response = cfg.resp_en;
                end else begin
                  fail_req = 1'b1;
                  fail_err = ERR_TLS;
                end
              end
              PH_MODE: begin
                if (ev.c_greet_ok || ev.c_ge500) begin
                  // authenticate or go ready
                  if (cfg.has_user) begin
                    phase_next     = PH_USER;
                    r.action       = ACT_USER;
                    r.arm_response = cfg.resp_en;
                  end else begin
                    phase_next     = PH_READY;
                    r.start_idle   = cfg.idle_en;
                    r.became_ready = 1'b1;
                  end
                end else begin
                  fail_req = 1'b1;
                  fail_err = ERR_PROTOCOL;
                end
              end
              PH_USER: begin
                if (ev.c_381) begin
                  phase_next     = PH_PASS;
                  r.action       = ACT_PASS;
                  r.arm_response = cfg.resp_en;
                end else if (ev.c_281) begin
                  phase_next     = PH_READY;
                  r.start_idle   = cfg.idle_en;
                  r.became_ready = 1'b1;
                end else begin
                  fail_req = 1'b1;
                  fail_err = ERR_AUTH;
                end
              end
              PH_PASS: begin
                if (ev.c_281) begin
                  phase_next     = PH_READY;
                  r.start_idle   = cfg.idle_en;
                  r.became_ready = 1'b1;
                end else begin
                  fail_req = 1'b1;
                  fail_err = ev.c_auth_fail ? ERR_AUTH : ERR_PROTOCOL;
                end
              end
              PH_CSTAT: begin
                if (!command_pending) begin
                  fail_req = 1'b1;
                  fail_err = ERR_PROTOCOL;
                end else begin
                  r.forward_status = 1'b1;
                  if (!ev.cfail && ev.cbody) begin
                    phase_next     = PH_CBODY;
                    r.arm_response = cfg.resp_en;
                  end else begin
                    r.command_done       = 1'b1;
                    command_pending_next = 1'b0;
                    phase_next           = PH_READY;
                    r.start_idle         = cfg.idle_en;
                  end
                end
              end
              PH_QUIT: begin
                phase_next = PH_DISC;
                r.action   = ACT_HANGUP;
              end
              PH_READY: begin
                fail_req = 1'b1;
                fail_err = ERR_PROTOCOL;
              end
              default: ;
            endcase
          end
        end
      end
      EV_BODY: begin
        if (phase == PH_CBODY) begin
          if (ev.term) begin
            r.command_done       = command_pending;
            command_pending_next = 1'b0;
            phase_next           = PH_READY;
            r.stop_timers        = 1'b1;
            r.start_idle         = cfg.idle_en;
          end else begin
            r.arm_response = cfg.resp_en;
            if (command_pending) begin
              r.forward_body     = 1'b1;
              r.strip_first_byte = ev.ldot;
            end
          end
        end
      end
      EV_TLS: begin
        if (phase == PH_STLS) begin
          if (cfg.has_user) begin
            phase_next     = PH_USER;
            r.action       = ACT_USER;
            r.arm_response = cfg.resp_en;
          end else begin
            phase_next     = PH_READY;
            r.stop_timers  = 1'b1;
            r.start_idle   = cfg.idle_en;
            r.became_ready = 1'b1;
          end
        end
      end
      EV_RTO: begin
        fail_req = 1'b1;
        fail_err = ERR_TIMEOUT;
      end
      EV_ITO, EV_CLOSE: begin
        if (phase == PH_READY) begin
          r.stop_timers  = 1'b1;
          phase_next     = PH_QUIT;
          r.action       = ACT_QUIT;
          r.arm_response = cfg.resp_en;
        end else if (ev.kind == EV_CLOSE && phase != PH_DISC) begin
          r.stop_timers = 1'b1;
          r.action      = ACT_ABORT;
          phase_next    = PH_DISC;
        end
      end
      EV_SUBMIT: begin
        if (phase == PH_READY) begin
          r.stop_timers        = 1'b1;
          command_pending_next = 1'b1;
          phase_next           = PH_CSTAT;
          r.action             = ACT_REQUEST;
          r.arm_response       = cfg.resp_en;
        end else begin
          r.command_done = 1'b1;
          r.error_kind   = ERR_PROTOCOL;
        end
      end
      EV_LOST: begin
        r.stop_timers = 1'b1;
        if (phase != PH_QUIT && phase != PH_DISC && !failed_latch) begin
          failed_latch_next    = 1'b1;
          r.command_done       = command_pending;
          command_pending_next = 1'b0;
          r.error_kind         = ERR_DISC;
          r.action             = ACT_ABORT;
        end
        phase_next      = PH_DISC;
        r.closed_notice = 1'b1;
      end
      EV_ERROR: begin
        if (phase != PH_QUIT && phase != PH_DISC) begin
          fail_req = 1'b1;
          fail_err = ev.sock_err;
        end
      end
      EV_ABORT: begin
        r.stop_timers = 1'b1;
        r.action      = ACT_ABORT;
        phase_next    = PH_DISC;
      end
      default: ;
    endcase

    // session failure, taken once until the next connect
    if (fail_req && !failed_latch) begin
      failed_latch_next = 1'b1;
      r.stop_timers     = 1'b1;
      r.arm_response    = 1'b0;
      r.start_idle      = 1'b0;
      if (command_pending) begin
        r.command_done = 1'b1;
      end
      command_pending_next = 1'b0;
      r.error_kind         = fail_err;
      r.action             = (phase != PH_DISC) ? ACT_ABORT : ACT_NONE;
      phase_next           = PH_DISC;
    end

    r.session_phase = phase_code(phase_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_DISC;
      failed_latch    <= 1'b0;
      command_pending <= 1'b0;
      wr_ptr          <= '0;
      rd_ptr          <= '0;
      count           <= '0;
    end else begin
      if (ev_take) begin
        phase           <= phase_next;
        failed_latch    <= failed_latch_next;
        command_pending <= command_pending_next;
        wr_ptr          <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (ev_take && !do_pop) begin
        count <= count + 1'b1;
      end else if (!ev_take && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_take) begin
      rq[wr_ptr] <= r;
    end
  end

endmodule

// ===== design/nntp_client_session_fsm.sv =====
// top level of the nntp client session controller
// depends on nntp_pkg, nntp_front, nntp_evq and nntp_exec

// Client side of an NNTP session, driven one event item at a time. Push an
// event while full is low; one result item comes back for every event, in
// order, and is read while empty is low and taken with pop. An event is
// classified and written into the event queue, then the back transition
// writes its result into the result queue. The block sustains one item per
// cycle while the result queue is popped. Each side has a two-entry queue,
// so input and output stall on their own. Configuration writes (tls mode,
// user present, idle timer, response timer) are always accepted and should
// only be made while no item is in flight.

module nntp_client_session_fsm
  import nntp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // event input
  input  logic       push,
  output logic       full,
  input  logic [3:0] opcode,
  input  logic [9:0] status_code,
  input  logic       code_valid,
  input  logic       body_is_terminator,
  input  logic       body_leading_dot,
  input  logic       cmd_reports_failed,
  input  logic       cmd_expects_body,
  input  logic [1:0] sock_error_kind,
  input  logic       server_valid,
  // result output
  output logic       empty,
  input  logic       pop,
  output logic [3:0] action,
  output logic       arm_response,
  output logic       start_idle,
  output logic       stop_timers,
  output logic [2:0] error_kind,
  output logic       command_done,
  output logic       forward_status,
  output logic       forward_body,
  output logic       strip_first_byte,
  output logic       became_ready,
  output logic       closed_notice,
  output logic [3:0] session_phase,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_data
);

  ev_t     front_ev;
  ev_t     q_ev;
  logic    q_full;
  logic    q_empty;
  logic    q_take;
  res_t    res;
  cfg_wr_t cfg_wr;

  // config registers have no busy time
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  assign full = q_full;

  // opcode decode and reply code classification
  nntp_front u_front (
    .opcode             (opcode),
    .status_code        (status_code),
    .code_valid         (code_valid),
    .body_is_terminator (body_is_terminator),
    .body_leading_dot   (body_leading_dot),
    .cmd_reports_failed (cmd_reports_failed),
    .cmd_expects_body   (cmd_expects_body),
    .sock_error_kind    (sock_error_kind),
    .server_valid       (server_valid),
    .ev                 (front_ev)
  );

  // decouples intake from the session back end
  nntp_evq u_evq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !q_full),
    .wr_data (front_ev),
    .full    (q_full),
    .rd_en   (q_take),
    .empty   (q_empty),
    .rd_data (q_ev)
  );

  // session state, transition and result queue
  nntp_exec u_exec (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .ev_avail (!q_empty),
    .ev       (q_ev),
    .ev_take  (q_take),
    .pop      (pop),
    .empty    (empty),
    .res      (res)
  );

  assign action           = res.action;
  assign arm_response     = res.arm_response;
  assign start_idle       = res.start_idle;
  assign stop_timers      = res.stop_timers;
  assign error_kind       = res.error_kind;
  assign command_done     = res.command_done;
  assign forward_status   = res.forward_status;
  assign forward_body     = res.forward_body;
  assign strip_first_byte = res.strip_first_byte;
  assign became_ready     = res.became_ready;
  assign closed_notice    = res.closed_notice;
  assign session_phase    = res.session_phase;

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for nntp_client_session_fsm: event items in, result items out
// depends on nntp_pkg for codes and the result struct; the expected results come from
// a session predictor kept in this file

module testbench
  import nntp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // one event item as it is offered on the input side
  typedef struct packed {
    logic [3:0] opcode;
    logic [9:0] status_code;
    logic       code_valid;
    logic       body_is_terminator;
    logic       body_leading_dot;
    logic       cmd_reports_failed;
    logic       cmd_expects_body;
    logic [1:0] sock_error_kind;
    logic       server_valid;
  } sess_event_t;

  // session phase as it shows on session_phase
  typedef enum logic [3:0] {
    SS_DISC, SS_GREET, SS_STLS, SS_MODE, SS_USER,
    SS_PASS, SS_READY, SS_CSTAT, SS_CBODY, SS_QUIT
  } sess_phase_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 250;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [3:0] opcode = '0;
  logic [9:0] status_code = '0;
  logic       code_valid = 1'b0;
  logic       body_is_terminator = 1'b0;
  logic       body_leading_dot = 1'b0;
  logic       cmd_reports_failed = 1'b0;
  logic       cmd_expects_body = 1'b0;
  logic [1:0] sock_error_kind = '0;
  logic       server_valid = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [3:0] action;
  logic       arm_response;
  logic       start_idle;
  logic       stop_timers;
  logic [2:0] error_kind;
  logic       command_done;
  logic       forward_status;
  logic       forward_body;
  logic       strip_first_byte;
  logic       became_ready;
  logic       closed_notice;
  logic [3:0] session_phase;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [1:0] cfg_data = '0;

  nntp_client_session_fsm dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .opcode(opcode), .status_code(status_code), .code_valid(code_valid),
    .body_is_terminator(body_is_terminator), .body_leading_dot(body_leading_dot),
    .cmd_reports_failed(cmd_reports_failed), .cmd_expects_body(cmd_expects_body),
    .sock_error_kind(sock_error_kind), .server_valid(server_valid),
    .empty(empty), .pop(pop),
    .action(action), .arm_response(arm_response), .start_idle(start_idle),
    .stop_timers(stop_timers), .error_kind(error_kind), .command_done(command_done),
    .forward_status(forward_status), .forward_body(forward_body),
    .strip_first_byte(strip_first_byte), .became_ready(became_ready),
    .closed_notice(closed_notice), .session_phase(session_phase),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // items waiting to be offered, and results predicted for accepted items
  sess_event_t pending_events[$];
  res_t        expected_results[$];

  // predictor copy of the registers and the session state
  cfg_t        cfg = '0;
  sess_phase_t sess = SS_DISC;
  logic        fail_latch = 1'b0;
  logic        cmd_pending = 1'b0;
  res_t        pred_res;

  int mismatch_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int events_queued = 0;
  int reg_writes = 0;
  int long_holds = 0;

  // ---------------------------------------------------------------------------
  // session predictor
  // ---------------------------------------------------------------------------

  function automatic void arm_timer();
    pred_res.arm_response = cfg.resp_en;
  endfunction

  // a failure ends the session once; later failures stay silent until reconnect
  function automatic void fail_session(logic [2:0] err);
    if (fail_latch) return;
    fail_latch = 1'b1;
    pred_res.stop_timers  = 1'b1;
    pred_res.arm_response = 1'b0;
    pred_res.start_idle   = 1'b0;
    if (cmd_pending) begin
      pred_res.command_done = 1'b1;
      cmd_pending = 1'b0;
    end
    pred_res.error_kind = err;
    pred_res.action     = (sess != SS_DISC) ? ACT_ABORT : ACT_NONE;
    sess = SS_DISC;
  endfunction

  function automatic void enter_ready();
    sess = SS_READY;
    pred_res.stop_timers  = 1'b1;
    pred_res.start_idle   = cfg.idle_en;
    pred_res.became_ready = 1'b1;
  endfunction

  function automatic void login_or_ready();
    if (cfg.has_user) begin
      sess = SS_USER;
      pred_res.action = ACT_USER;
      arm_timer();
    end else begin
      enter_ready();
    end
  endfunction

  function automatic void finish_command();
    pred_res.command_done = cmd_pending;
    cmd_pending = 1'b0;
    sess = SS_READY;
    pred_res.stop_timers  = 1'b1;
    pred_res.arm_response = 1'b0;
    pred_res.start_idle   = cfg.idle_en;
  endfunction

  function automatic void abort_session();
    pred_res.stop_timers = 1'b1;
    pred_res.action      = ACT_ABORT;
    sess = SS_DISC;
  endfunction

  function automatic res_t step_session(sess_event_t e);
    logic [9:0] code;
    logic       was_quit;
    code = e.status_code;
    pred_res = '0;
    case (e.opcode)
      OP_CONNECT: begin
        if (sess == SS_DISC) begin
          if (!e.server_valid) begin
            fail_session(ERR_CONNECT);
          end else begin
            fail_latch = 1'b0;
            pred_res.action = (cfg.tls_mode == TLS_IMPLICIT) ? ACT_OPEN_TLS : ACT_OPEN;
            sess = SS_GREET;
            arm_timer();
          end
        end
      end
      OP_STATUS: begin
        // status lines are not looked at while a body is streaming
        if (sess != SS_CBODY) begin
          if (!e.code_valid) begin
            fail_session(ERR_PROTOCOL);
          end else begin
            pred_res.stop_timers = 1'b1;
            case (sess)
              SS_GREET: begin
                if (code == CODE_200 || code == CODE_201) begin
                  if (cfg.tls_mode == TLS_STARTTLS) begin
                    sess = SS_STLS;
                    pred_res.action = ACT_STARTTLS;
                  end else begin
                    sess = SS_MODE;
                    pred_res.action = ACT_MODE;
                  end
                  arm_timer();
                end else if (code == CODE_400 || code == CODE_502) begin
                  fail_session(ERR_UNAVAIL);
                end else begin
                  fail_session(ERR_PROTOCOL);
                end
              end
              SS_STLS: begin
                if (code == CODE_382) begin
                  pred_res.action = ACT_START_TLS;
                  arm_timer();
                end else begin
                  fail_session(ERR_TLS);
                end
              end
              SS_MODE: begin
                if (code == CODE_200 || code == CODE_201 || code >= CODE_500) login_or_ready();
                else fail_session(ERR_PROTOCOL);
              end
              SS_USER: begin
                if (code == CODE_381) begin
                  sess = SS_PASS;
                  pred_res.action = ACT_PASS;
                  arm_timer();
                end else if (code == CODE_281) begin
                  enter_ready();
                end else begin
                  fail_session(ERR_AUTH);
                end
              end
              SS_PASS: begin
                if (code == CODE_281) enter_ready();
                else if (code == CODE_481 || code == CODE_482 || code == CODE_502)
                  fail_session(ERR_AUTH);
                else fail_session(ERR_PROTOCOL);
              end
              SS_CSTAT: begin
                if (!cmd_pending) begin
                  fail_session(ERR_PROTOCOL);
                end else begin
                  pred_res.forward_status = 1'b1;
                  if (!e.cmd_reports_failed && e.cmd_expects_body) begin
                    sess = SS_CBODY;
                    arm_timer();
                  end else begin
                    finish_command();
                  end
                end
              end
              SS_QUIT: begin
                sess = SS_DISC;
                pred_res.action = ACT_HANGUP;
              end
              SS_READY: fail_session(ERR_PROTOCOL);
              default: ;
            endcase
          end
        end
      end
      OP_BODY: begin
        if (sess == SS_CBODY) begin
          if (e.body_is_terminator) begin
            finish_command();
          end else begin
            arm_timer();
            if (cmd_pending) begin
              pred_res.forward_body     = 1'b1;
              pred_res.strip_first_byte = e.body_leading_dot;
            end
          end
        end
      end
      OP_TLS: begin
        if (sess == SS_STLS) login_or_ready();
      end
      OP_RTO: fail_session(ERR_TIMEOUT);
      OP_ITO, OP_CLOSE: begin
        if (!(e.opcode == OP_ITO && sess != SS_READY) && sess != SS_DISC) begin
          if (sess == SS_READY) begin
            pred_res.stop_timers = 1'b1;
            sess = SS_QUIT;
            pred_res.action = ACT_QUIT;
            arm_timer();
          end else begin
            abort_session();
          end
        end
      end
      OP_SUBMIT: begin
        if (sess == SS_READY) begin
          pred_res.stop_timers = 1'b1;
          cmd_pending = 1'b1;
          sess = SS_CSTAT;
          pred_res.action = ACT_REQUEST;
          arm_timer();
        end else begin
          pred_res.command_done = 1'b1;
          pred_res.error_kind   = ERR_PROTOCOL;
        end
      end
      OP_LOST: begin
        was_quit = (sess == SS_QUIT);
        pred_res.stop_timers = 1'b1;
        if (!was_quit && sess != SS_DISC && !fail_latch) fail_session(ERR_DISC);
        sess = SS_DISC;
        pred_res.arm_response  = 1'b0;
        pred_res.start_idle    = 1'b0;
        pred_res.closed_notice = 1'b1;
      end
      OP_ERROR: begin
        if (sess != SS_QUIT && sess != SS_DISC) begin
          if (e.sock_error_kind == SOCK_TLS_FAIL) fail_session(ERR_TLS);
          else if (e.sock_error_kind == SOCK_REMOTE) fail_session(ERR_DISC);
          else fail_session(ERR_CONNECT);
        end
      end
      OP_ABORT: abort_session();
      default: ;
    endcase
    pred_res.session_phase = sess;
    return pred_res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  // item with the given opcode, valid code and server, and random content in the other fields
  function automatic sess_event_t rand_event(logic [3:0] op);
    sess_event_t e;
    e.opcode             = op;
    e.status_code        = 10'($urandom_range(0, 999));
    e.code_valid         = 1'b1;
    e.body_is_terminator = 1'($urandom_range(0, 1));
    e.body_leading_dot   = 1'($urandom_range(0, 1));
    e.cmd_reports_failed = 1'($urandom_range(0, 1));
    e.cmd_expects_body   = 1'($urandom_range(0, 1));
    e.sock_error_kind    = 2'($urandom_range(0, 2));
    e.server_valid       = 1'b1;
    return e;
  endfunction

  // fixed item for the directed part
  function automatic sess_event_t fixed_event(logic [3:0] op, logic [9:0] code);
    sess_event_t e;
    e = '0;
    e.opcode      = op;
    e.status_code = code;
    e.code_valid  = 1'b1;
    e.server_valid = 1'b1;
    return e;
  endfunction

  // one of the codes the session reacts to, or anything in range
  function automatic logic [9:0] pick_code();
    case ($urandom_range(0, 11))
      0: return CODE_200;
      1: return CODE_201;
      2: return CODE_281;
      3: return CODE_381;
      4: return CODE_382;
      5: return CODE_400;
      6: return CODE_481;
      7: return CODE_482;
      8: return CODE_500;
      9: return CODE_502;
      default: return 10'($urandom_range(0, 999));
    endcase
  endfunction

  // queue an item, now and then preceded by a stray one
  task automatic queue_event(sess_event_t e);
    sess_event_t stray;
    if ($urandom_range(0, 24) == 0) begin
      stray = rand_event(4'($urandom_range(0, 10)));
      stray.code_valid   = ($urandom_range(0, 7) != 0);
      stray.server_valid = ($urandom_range(0, 3) != 0);
      stray.status_code  = pick_code();
      pending_events.push_back(stray);
      events_queued++;
    end
    pending_events.push_back(e);
    events_queued++;
  endtask

  task automatic queue_status(logic [9:0] code);
    sess_event_t e;
    e = rand_event(OP_STATUS);
    e.status_code = code;
    queue_event(e);
  endtask

  // mostly well-formed session for the current register setting:
  // connect, greeting, optional starttls, mode reader, optional login,
  // a few commands with bodies, then some way of ending
  task automatic add_session();
    sess_event_t e;
    int n_lines;
    e = rand_event(OP_CONNECT);
    e.server_valid = ($urandom_range(0, 15) != 0);
    queue_event(e);
    if ($urandom_range(0, 9) == 0) queue_status(pick_code());
    else queue_status($urandom_range(0, 1) ? CODE_200 : CODE_201);
    if (cfg.tls_mode == TLS_STARTTLS) begin
      queue_status(($urandom_range(0, 9) == 0) ? pick_code() : CODE_382);
      queue_event(rand_event(OP_TLS));
    end
    case ($urandom_range(0, 9))
      0:       queue_status(pick_code());
      1, 2, 3: queue_status(CODE_200);
      4, 5:    queue_status(CODE_201);
      default: queue_status(10'($urandom_range(500, 999)));
    endcase
    if (cfg.has_user) begin
      if ($urandom_range(0, 3) == 0) begin
        queue_status(CODE_281);
      end else begin
        queue_status(($urandom_range(0, 9) == 0) ? pick_code() : CODE_381);
        case ($urandom_range(0, 9))
          0:       queue_status(CODE_481);
          1:       queue_status(CODE_482);
          2:       queue_status(CODE_502);
          3:       queue_status(pick_code());
          default: queue_status(CODE_281);
        endcase
      end
    end
    repeat ($urandom_range(0, 5)) begin
      queue_event(rand_event(OP_SUBMIT));
      e = rand_event(OP_STATUS);
      e.cmd_reports_failed = ($urandom_range(0, 4) == 0);
      e.cmd_expects_body   = ($urandom_range(0, 2) != 0);
      queue_event(e);
      if (e.cmd_expects_body && !e.cmd_reports_failed) begin
        n_lines = $urandom_range(0, 4);
        repeat (n_lines) begin
          e = rand_event(OP_BODY);
          e.body_is_terminator = 1'b0;
          queue_event(e);
        end
        e = rand_event(OP_BODY);
        e.body_is_terminator = 1'b1;
        queue_event(e);
      end
    end
    case ($urandom_range(0, 7))
      0, 1, 2: begin
        queue_event(rand_event(OP_CLOSE));
        queue_status(pick_code());
      end
      3: begin
        queue_event(rand_event(OP_ITO));
        queue_status(pick_code());
      end
      4: queue_event(rand_event(OP_LOST));
      5: queue_event(rand_event(OP_ABORT));
      6: queue_event(rand_event(OP_ERROR));
      default: queue_event(rand_event(OP_RTO));
    endcase
    if ($urandom_range(0, 1)) queue_event(rand_event(OP_LOST));
  endtask

  // register write over the config channel, only ever called with nothing in flight
  task automatic write_reg(logic [1:0] idx, logic [1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TLS_MODE: cfg.tls_mode = val;
      CFG_HAS_USER: cfg.has_user = val[0];
      CFG_IDLE_EN:  cfg.idle_en  = val[0];
      CFG_RESP_EN:  cfg.resp_en  = val[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // sender pause: waits until nothing is queued and nothing is expected
  task automatic wait_drained();
    while (pending_events.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // input driver: bursts of random length, random gaps in between
  // ---------------------------------------------------------------------------

  int burst_left = 4;
  int gap_left = 0;

  always @(posedge clk) begin : event_driver
    logic offer;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(step_session(pending_events.pop_front()));
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          // about half the bursts run straight into the next one
          gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
        end
      end else if (!push && gap_left > 0) begin
        gap_left--;
      end
      offer = (gap_left == 0) && (pending_events.size() != 0);
      push <= offer;
      if (offer) begin
        opcode             <= pending_events[0].opcode;
        status_code        <= pending_events[0].status_code;
        code_valid         <= pending_events[0].code_valid;
        body_is_terminator <= pending_events[0].body_is_terminator;
        body_leading_dot   <= pending_events[0].body_leading_dot;
        cmd_reports_failed <= pending_events[0].cmd_reports_failed;
        cmd_expects_body   <= pending_events[0].cmd_expects_body;
        sock_error_kind    <= pending_events[0].sock_error_kind;
        server_valid       <= pending_events[0].server_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: stall pattern of its own, plus up to two long holds
  // ---------------------------------------------------------------------------

  int rx_tick = 0;
  int rx_mode = 0;
  int hold_left = 0;

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    res_t got;
    res_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got = {action, arm_response, start_idle, stop_timers, error_kind, command_done,
               forward_status, forward_body, strip_first_byte, became_ready,
               closed_notice, session_phase};
        if (expected_results.size() == 0) begin
          $error("result item with no expectation waiting");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("action", want.action, got.action);
          check_field("arm_response", want.arm_response, got.arm_response);
          check_field("start_idle", want.start_idle, got.start_idle);
          check_field("stop_timers", want.stop_timers, got.stop_timers);
          check_field("error_kind", want.error_kind, got.error_kind);
          check_field("command_done", want.command_done, got.command_done);
          check_field("forward_status", want.forward_status, got.forward_status);
          check_field("forward_body", want.forward_body, got.forward_body);
          check_field("strip_first_byte", want.strip_first_byte, got.strip_first_byte);
          check_field("became_ready", want.became_ready, got.became_ready);
          check_field("closed_notice", want.closed_notice, got.closed_notice);
          check_field("session_phase", want.session_phase, got.session_phase);
        end
        results_checked++;
        // hold off while the sender still has plenty to offer, so both queues fill
        if (long_holds < 2 && results_checked >= 300 + 500 * long_holds &&
            pending_events.size() > 30) begin
          hold_left = LONG_HOLD;
          long_holds++;
        end
      end
      rx_tick++;
      if (rx_tick % 48 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (rx_mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          2:       pop <= ($urandom_range(0, 4) == 0);
          default: pop <= (rx_tick % 4 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: cycles with no handshake of any kind
  // ---------------------------------------------------------------------------

  int quiet_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d items queued, %0d results still expected",
               pending_events.size(), expected_results.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : main_sequence
    sess_event_t e;
    int setting;
    int target;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part, under reset register values (cleartext, no user, timers off)
    pending_events.push_back(fixed_event(OP_STATUS, 10'd0));     // status while disconnected
    e = fixed_event(OP_STATUS, 10'd999);
    e.code_valid = 1'b0;                                         // unparsable code, latches
    pending_events.push_back(e);
    pending_events.push_back(fixed_event(OP_RTO, 10'd0));        // latched: silent
    e = fixed_event(OP_CONNECT, 10'd0);
    e.server_valid = 1'b0;                                       // no host while latched
    pending_events.push_back(e);
    pending_events.push_back(fixed_event(OP_CONNECT, 10'd0));
    pending_events.push_back(fixed_event(OP_STATUS, 10'd999));   // bad greeting
    pending_events.push_back(fixed_event(OP_CONNECT, 10'd0));
    pending_events.push_back(fixed_event(OP_STATUS, CODE_400));  // service unavailable
    pending_events.push_back(fixed_event(OP_CONNECT, 10'd0));
    pending_events.push_back(fixed_event(OP_STATUS, CODE_201));
    pending_events.push_back(fixed_event(OP_STATUS, CODE_500));  // mode reader refused is fine
    pending_events.push_back(fixed_event(OP_SUBMIT, 10'd0));
    e = fixed_event(OP_STATUS, CODE_200);
    e.cmd_expects_body = 1'b1;
    pending_events.push_back(e);
    e = fixed_event(OP_BODY, 10'd0);
    e.body_leading_dot = 1'b1;                                   // dot-stuffed line
    pending_events.push_back(e);
    pending_events.push_back(fixed_event(OP_STATUS, CODE_200));  // status inside body: ignored
    e = fixed_event(OP_BODY, 10'd0);
    e.body_is_terminator = 1'b1;
    pending_events.push_back(e);
    pending_events.push_back(fixed_event(OP_TLS, 10'd0));        // tls done outside starttls
    pending_events.push_back(fixed_event(OP_ITO, 10'd0));        // idle timeout sends quit
    pending_events.push_back(fixed_event(OP_STATUS, 10'd0));     // reply to quit
    pending_events.push_back(fixed_event(OP_ERROR, 10'd0));      // socket error while disconnected
    pending_events.push_back(fixed_event(OP_SUBMIT, 10'd0));     // submit when not ready
    pending_events.push_back(fixed_event(OP_BODY, 10'd0));       // body outside body
    pending_events.push_back(fixed_event(OP_ABORT, 10'd0));
    pending_events.push_back(fixed_event(OP_CONNECT, 10'd0));
    e = fixed_event(OP_ERROR, 10'd0);
    e.sock_error_kind = SOCK_REMOTE;
    pending_events.push_back(e);
    pending_events.push_back(fixed_event(OP_LOST, 10'd0));
    wait_drained();

    // random part: one register setting per round, extremes first
    for (setting = 0; setting < 8; setting++) begin
      case (setting)
        0: begin
          write_reg(CFG_TLS_MODE, 2'd0);
          write_reg(CFG_HAS_USER, 2'd0);
          write_reg(CFG_IDLE_EN, 2'd0);
          write_reg(CFG_RESP_EN, 2'd0);
        end
        1: begin
          write_reg(CFG_TLS_MODE, TLS_STARTTLS);
          write_reg(CFG_HAS_USER, 2'd1);
          write_reg(CFG_IDLE_EN, 2'd1);
          write_reg(CFG_RESP_EN, 2'd1);
        end
        2: begin
          write_reg(CFG_TLS_MODE, TLS_IMPLICIT);
          write_reg(CFG_HAS_USER, 2'd1);
          write_reg(CFG_IDLE_EN, 2'd0);
          write_reg(CFG_RESP_EN, 2'd1);
        end
        default: begin
          write_reg(CFG_TLS_MODE, 2'($urandom_range(0, 2)));
          write_reg(CFG_HAS_USER, 2'($urandom_range(0, 1)));
          write_reg(CFG_IDLE_EN, 2'($urandom_range(0, 1)));
          write_reg(CFG_RESP_EN, 2'($urandom_range(0, 1)));
        end
      endcase
      target = events_queued + 150;
      while (events_queued < target) add_session();
      wait_drained();
    end

    $display("summary: %0d event items, %0d results checked, %0d register writes, %0d long holds",
             items_sent, results_checked, reg_writes, long_holds);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== nntp_client_session_fsm.f =====
design/nntp_pkg.sv
design/nntp_front.sv
design/nntp_evq.sv
design/nntp_exec.sv
design/nntp_client_session_fsm.sv
verif/testbench.sv
